### rtl/vmmio_pkg.sv
package vmmio_pkg;

    localparam int QUEUE_SIZE_MAX_DEF = 128;
    localparam int CAP_W              = 48;
    localparam int OFF_W              = 12;
    localparam int DATA_W             = 32;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_EVENT = 2'd2
    } t_mode;

    localparam logic [1:0] SIZE_WORD = 2'd2;

    // Identity and feature words.
    localparam logic [31:0] MAGIC_WORD       = 32'h7472_6976;
    localparam logic [31:0] VERSION_WORD     = 32'd2;
    localparam logic [31:0] DEVICE_ID_WORD   = 32'd2;
    localparam logic [31:0] VENDOR_WORD      = 32'h5241_3844;
    localparam logic [31:0] FEAT_READ_ONLY   = 32'h0000_0020;
    localparam logic [31:0] FEAT_VERSION_ONE = 32'h0000_0001;

    // Register offsets.
    localparam logic [OFF_W-1:0] OFF_MAGIC        = 12'h000;
    localparam logic [OFF_W-1:0] OFF_VERSION      = 12'h004;
    localparam logic [OFF_W-1:0] OFF_DEVICE_ID    = 12'h008;
    localparam logic [OFF_W-1:0] OFF_VENDOR       = 12'h00c;
    localparam logic [OFF_W-1:0] OFF_DEV_FEAT     = 12'h010;
    localparam logic [OFF_W-1:0] OFF_DEV_FEAT_SEL = 12'h014;
    localparam logic [OFF_W-1:0] OFF_DRV_FEAT     = 12'h020;
    localparam logic [OFF_W-1:0] OFF_DRV_FEAT_SEL = 12'h024;
    localparam logic [OFF_W-1:0] OFF_QUEUE_MAX    = 12'h034;
    localparam logic [OFF_W-1:0] OFF_QUEUE_SIZE   = 12'h038;
    localparam logic [OFF_W-1:0] OFF_QUEUE_READY  = 12'h044;
    localparam logic [OFF_W-1:0] OFF_QUEUE_NOTIFY = 12'h050;
    localparam logic [OFF_W-1:0] OFF_INT_STATUS   = 12'h060;
    localparam logic [OFF_W-1:0] OFF_INT_ACK      = 12'h064;
    localparam logic [OFF_W-1:0] OFF_STATUS       = 12'h070;
    localparam logic [OFF_W-1:0] OFF_DESC_LO      = 12'h080;
    localparam logic [OFF_W-1:0] OFF_DESC_HI      = 12'h084;
    localparam logic [OFF_W-1:0] OFF_AVAIL_LO     = 12'h090;
    localparam logic [OFF_W-1:0] OFF_AVAIL_HI     = 12'h094;
    localparam logic [OFF_W-1:0] OFF_USED_LO      = 12'h0a0;
    localparam logic [OFF_W-1:0] OFF_USED_HI      = 12'h0a4;
    localparam logic [OFF_W-1:0] OFF_CAP_LO       = 12'h100;
    localparam logic [OFF_W-1:0] OFF_CAP_HI       = 12'h104;

    typedef struct packed {
        logic [1:0]        mode;
        logic [OFF_W-1:0]  reg_offset;
        logic [DATA_W-1:0] write_data;
        logic [1:0]        access_size;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_level;
        logic              notify_pulse;
        logic              ring_restart;
    } t_rsp;

endpackage

### rtl/vmmio_if.sv
interface vmmio_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic [vmmio_pkg::OFF_W-1:0]   reg_offset;
    logic [vmmio_pkg::DATA_W-1:0]  write_data;
    logic [1:0]                    access_size;

    modport source (output valid, mode, reg_offset, write_data, access_size, input ready);
    modport sink (input valid, mode, reg_offset, write_data, access_size, output ready);
endinterface

interface vmmio_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [vmmio_pkg::DATA_W-1:0]  read_data;
    logic                          irq_level;
    logic                          notify_pulse;
    logic                          ring_restart;

    modport source (output valid, read_data, irq_level, notify_pulse, ring_restart,
                    input ready);
    modport sink (input valid, read_data, irq_level, notify_pulse, ring_restart,
                  output ready);
endinterface

### rtl/vmmio_regs.sv
module vmmio_regs #(
    parameter int QUEUE_SIZE_MAX = vmmio_pkg::QUEUE_SIZE_MAX_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  vmmio_pkg::t_req             i_req,
    input  logic                        i_cfg_we,
    input  logic [vmmio_pkg::CAP_W-1:0] i_cfg_data,
    output vmmio_pkg::t_rsp             o_rsp
);

    localparam int QW = (QUEUE_SIZE_MAX < 2) ? 1 : $clog2(QUEUE_SIZE_MAX + 1);
    localparam logic [31:0] QMAX_WORD = 32'(QUEUE_SIZE_MAX);

    logic [vmmio_pkg::CAP_W-1:0] r_capacity;
    logic [31:0]                 r_status,      n_status;
    logic [31:0]                 r_dev_sel,     n_dev_sel;
    logic [31:0]                 r_drv_sel,     n_drv_sel;
    logic [31:0]                 r_drv_feat0,   n_drv_feat0;
    logic [31:0]                 r_drv_feat1,   n_drv_feat1;
    logic [31:0]                 r_int_status,  n_int_status;
    logic [QW-1:0]               r_queue_size,  n_queue_size;
    logic                        r_queue_ready, n_queue_ready;
    logic [63:0]                 r_desc_addr,   n_desc_addr;
    logic [63:0]                 r_avail_addr,  n_avail_addr;
    logic [63:0]                 r_used_addr,   n_used_addr;

    logic        w_word;
    logic [31:0] w_rd;
    logic [31:0] w_feat;
    logic [31:0] w_wd;
    logic        w_notify;
    logic        w_restart;

    assign w_word = (i_req.access_size == vmmio_pkg::SIZE_WORD);
    assign w_wd   = i_req.write_data;

    always_comb begin
        priority if (r_dev_sel == 32'd0) begin
            w_feat = vmmio_pkg::FEAT_READ_ONLY;
        end else if (r_dev_sel == 32'd1) begin
            w_feat = vmmio_pkg::FEAT_VERSION_ONE;
        end else begin
            w_feat = '0;
        end
    end

    always_comb begin
        unique case (i_req.reg_offset)
            vmmio_pkg::OFF_MAGIC:       w_rd = vmmio_pkg::MAGIC_WORD;
            vmmio_pkg::OFF_VERSION:     w_rd = vmmio_pkg::VERSION_WORD;
            vmmio_pkg::OFF_DEVICE_ID:   w_rd = vmmio_pkg::DEVICE_ID_WORD;
            vmmio_pkg::OFF_VENDOR:      w_rd = vmmio_pkg::VENDOR_WORD;
            vmmio_pkg::OFF_DEV_FEAT:    w_rd = w_feat;
            vmmio_pkg::OFF_QUEUE_MAX:   w_rd = QMAX_WORD;
            vmmio_pkg::OFF_QUEUE_READY: w_rd = {31'd0, r_queue_ready};
            vmmio_pkg::OFF_INT_STATUS:  w_rd = r_int_status;
            vmmio_pkg::OFF_STATUS:      w_rd = r_status;
            vmmio_pkg::OFF_CAP_LO:      w_rd = r_capacity[31:0];
            vmmio_pkg::OFF_CAP_HI:      w_rd = {{(64 - vmmio_pkg::CAP_W){1'b0}},
                                               r_capacity[vmmio_pkg::CAP_W-1:32]};
            default:                    w_rd = '0;
        endcase
    end

    always_comb begin
        n_status      = r_status;
        n_dev_sel     = r_dev_sel;
        n_drv_sel     = r_drv_sel;
        n_drv_feat0   = r_drv_feat0;
        n_drv_feat1   = r_drv_feat1;
        n_int_status  = r_int_status;
        n_queue_size  = r_queue_size;
        n_queue_ready = r_queue_ready;
        n_desc_addr   = r_desc_addr;
        n_avail_addr  = r_avail_addr;
        n_used_addr   = r_used_addr;
        w_notify      = 1'b0;
        w_restart     = 1'b0;
        o_rsp.read_data = '0;

        unique case (i_req.mode)
            vmmio_pkg::MODE_READ: begin
                if (w_word) begin
                    o_rsp.read_data = w_rd;
                end
            end
            vmmio_pkg::MODE_WRITE: begin
                if (w_word) begin
                    unique case (i_req.reg_offset)
                        vmmio_pkg::OFF_DEV_FEAT_SEL: n_dev_sel = w_wd;
                        vmmio_pkg::OFF_DRV_FEAT_SEL: n_drv_sel = w_wd;
                        vmmio_pkg::OFF_DRV_FEAT: begin
                            if (r_drv_sel == 32'd0) begin
                                n_drv_feat0 = w_wd;
                            end else if (r_drv_sel == 32'd1) begin
                                n_drv_feat1 = w_wd;
                            end
                        end
                        vmmio_pkg::OFF_QUEUE_SIZE: begin
                            if (w_wd != 32'd0 && w_wd <= QMAX_WORD) begin
                                n_queue_size = w_wd[QW-1:0];
                            end
                        end
                        vmmio_pkg::OFF_QUEUE_READY: begin
                            n_queue_ready = w_wd[0];
                            w_restart     = w_wd[0];
                        end
                        vmmio_pkg::OFF_DESC_LO:  n_desc_addr[31:0]   = w_wd;
                        vmmio_pkg::OFF_DESC_HI:  n_desc_addr[63:32]  = w_wd;
                        vmmio_pkg::OFF_AVAIL_LO: n_avail_addr[31:0]  = w_wd;
                        vmmio_pkg::OFF_AVAIL_HI: n_avail_addr[63:32] = w_wd;
                        vmmio_pkg::OFF_USED_LO:  n_used_addr[31:0]   = w_wd;
                        vmmio_pkg::OFF_USED_HI:  n_used_addr[63:32]  = w_wd;
                        vmmio_pkg::OFF_QUEUE_NOTIFY: begin
                            w_notify = r_queue_ready && (r_queue_size != '0);
                        end
                        vmmio_pkg::OFF_INT_ACK: n_int_status = r_int_status & ~w_wd;
                        vmmio_pkg::OFF_STATUS: begin
                            n_status = w_wd;
                            // A status of zero is a device reset: the queue starts over.
                            if (w_wd == 32'd0) begin
                                n_queue_ready = 1'b0;
                                n_queue_size  = '0;
                                n_int_status  = '0;
                                w_restart     = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            vmmio_pkg::MODE_EVENT: n_int_status = r_int_status | 32'd1;
            default: ;
        endcase

        o_rsp.irq_level    = (n_int_status != 32'd0);
        o_rsp.notify_pulse = w_notify;
        o_rsp.ring_restart = w_restart;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity    <= vmmio_pkg::CAP_W'(1);
            r_status      <= '0;
            r_dev_sel     <= '0;
            r_drv_sel     <= '0;
            r_drv_feat0   <= '0;
            r_drv_feat1   <= '0;
            r_int_status  <= '0;
            r_queue_size  <= '0;
            r_queue_ready <= 1'b0;
            r_desc_addr   <= '0;
            r_avail_addr  <= '0;
            r_used_addr   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (i_en) begin
                r_status      <= n_status;
                r_dev_sel     <= n_dev_sel;
                r_drv_sel     <= n_drv_sel;
                r_drv_feat0   <= n_drv_feat0;
                r_drv_feat1   <= n_drv_feat1;
                r_int_status  <= n_int_status;
                r_queue_size  <= n_queue_size;
                r_queue_ready <= n_queue_ready;
                r_desc_addr   <= n_desc_addr;
                r_avail_addr  <= n_avail_addr;
                r_used_addr   <= n_used_addr;
            end
        end
    end

    a_event_sets_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_req.mode == vmmio_pkg::MODE_EVENT |=> r_int_status[0])
        else $error("completion event did not set interrupt status");

    a_irq_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |=> ($past(o_rsp.irq_level) == (r_int_status != 32'd0)))
        else $error("reported interrupt level differs from stored status");

    a_restart_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_rsp.ring_restart |=> (r_queue_ready || r_queue_size == '0))
        else $error("ring restart left queue in an unexpected state");

    a_notify_needs_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_rsp.notify_pulse |=> (r_queue_ready && r_queue_size != '0))
        else $error("notify issued without a ready, sized queue");

endmodule

### rtl/virtio_mmio_register_front_end_core.sv
// Dataflow: a request beat accepted into the request register is decoded, and its response beat
// is registered in the response register once that register is empty or being drained.
// Throughput: one request per cycle; a stalled response beat holds both registers and
// lowers i_req.ready. Decode and update sit between the request and response registers.
// Reset (synchronous, active low) clears all queue, interrupt and status state and
// sets the capacity register to one sector.
module virtio_mmio_register_front_end_core #(
    parameter int QUEUE_SIZE_MAX = vmmio_pkg::QUEUE_SIZE_MAX_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    vmmio_req_if.sink                   i_req,
    vmmio_rsp_if.source                 o_rsp,
    input  logic                        i_cfg_we,
    input  logic [vmmio_pkg::CAP_W-1:0] i_cfg_data
);

    logic            r_s_valid;
    vmmio_pkg::t_req r_s;
    logic            r_o_valid;
    vmmio_pkg::t_rsp r_o;
    vmmio_pkg::t_rsp w_rsp;
    logic            w_adv;

    // The stage moves on when the response register is empty or being drained.
    assign w_adv       = r_s_valid && (!r_o_valid || o_rsp.ready);
    assign i_req.ready = !r_s_valid || w_adv;

    vmmio_regs #(
        .QUEUE_SIZE_MAX (QUEUE_SIZE_MAX)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_req      (r_s),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_rsp      (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_s_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_s.mode        <= i_req.mode;
            r_s.reg_offset  <= i_req.reg_offset;
            r_s.write_data  <= i_req.write_data;
            r_s.access_size <= i_req.access_size;
        end
        if (w_adv) begin
            r_o <= w_rsp;
        end
    end

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.read_data    = r_o.read_data;
    assign o_rsp.irq_level    = r_o.irq_level;
    assign o_rsp.notify_pulse = r_o.notify_pulse;
    assign o_rsp.ring_restart = r_o.ring_restart;

    a_stage_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid && !w_adv |=> r_s_valid)
        else $error("held request beat was dropped");

    a_adv_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_o_valid)
        else $error("processed request produced no response beat");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s_valid && !(i_req.valid && i_req.ready) |=> !w_adv)
        else $error("stage advanced without a request beat");

endmodule
